>>> hw/rtl/png_stored_stream_encoder_top_assert.svh
// Assertion macros for the PNG stored stream encoder
`ifndef PNG_STORED_STREAM_ENCODER_TOP_ASSERT_SVH
`define PNG_STORED_STREAM_ENCODER_TOP_ASSERT_SVH
// implication checked at every clock edge outside reset
`define PSE_ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("%s failed", "label");
// next-cycle implication
`define PSE_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("%s failed", "label");
`endif

>>> hw/rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared constants and helpers of the PNG stored stream encoder.
// ----------------------------------------------------------------------------
package pse_pkg;
    localparam int MAX_SIDE    = 16384;
    localparam int BLOCK_LIMIT = 65535;
    localparam int CFG_W       = 15;
    localparam int SIDE_W      = 15;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    // register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // output item of the encoder
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       file_end;
    } pse_out_t;

    // pixel item
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pse_in_t;

    // byte of the fixed IEND chunk (index 0..11)
    function automatic logic [7:0] iend_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd4:    b = 8'h49;
            4'd5:    b = 8'h45;
            4'd6:    b = 8'h4E;
            4'd7:    b = 8'h44;
            4'd8:    b = 8'hAE;
            4'd9:    b = 8'h42;
            4'd10:   b = 8'h60;
            4'd11:   b = 8'h82;
            default: b = 8'h00;
        endcase
        return b;
    endfunction
endpackage

>>> hw/rtl/pse_stream_if.sv
// ----------------------------------------------------------------------------
// pse_stream_if
// Valid/ready channels carrying a pixel (pse_in_t) or an output byte item (pse_out_t).
// ----------------------------------------------------------------------------
interface pse_pix_if;
    import pse_pkg::*;
    logic    valid;
    logic    ready;
    pse_in_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pse_byte_if;
    import pse_pkg::*;
    logic     valid;
    logic     ready;
    pse_out_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/pse_crc_unit.sv
// ----------------------------------------------------------------------------
// pse_crc_unit
// Byte-wide CRC-32 and Adler-32 update unit, one byte per request.
// ----------------------------------------------------------------------------
module pse_crc_unit
    import pse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        crc_init,
    input  logic        crc_en,
    input  logic        adl_init,
    input  logic        adl_en,
    input  logic [7:0]  din,
    output logic [31:0] crc,
    output logic [15:0] adl_low,
    output logic [15:0] adl_high
);
    logic [31:0] crc_reg, crc_next;
    logic [15:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [16:0] lo_sum, hi_sum;

    // eight bit steps of the reflected CRC
    always_comb
    begin
        crc_next = crc_reg ^ {24'd0, din};
        for (int k = 0; k < 8; k++)
            crc_next = crc_next[0] ? (CRC_POLY ^ (crc_next >> 1)) : (crc_next >> 1);
    end

    // modular sums, operands stay below the modulus
    always_comb
    begin
        lo_sum  = {1'b0, lo_reg} + {9'd0, din};
        lo_next = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
        hi_sum  = {1'b0, hi_reg} + {1'b0, lo_next};
        hi_next = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= '1;
            lo_reg  <= 16'd1;
            hi_reg  <= '0;
        end
        else
        begin
            if (crc_init)
                crc_reg <= '1;
            else if (crc_en)
                crc_reg <= crc_next;
            if (adl_init)
            begin
                lo_reg <= 16'd1;
                hi_reg <= '0;
            end
            else if (adl_en)
            begin
                lo_reg <= lo_next;
                hi_reg <= hi_next;
            end
        end
    end

    assign crc      = crc_reg;
    assign adl_low  = lo_reg;
    assign adl_high = hi_reg;
endmodule

>>> hw/rtl/png_stored_stream_encoder_top.sv
// Flow: a pixel is accepted in ST_IDLE, then its 4 raw bytes (5 with the row
// filter byte) leave at one byte per cycle while the output is ready; a block
// header adds 5 bytes. The first pixel of a file adds 43 header bytes, the last one
// adds 20 trailer bytes. A new pixel is accepted only once all bytes of the last
// one have left the sequencer.
// Reset: asynchronous active low; the next pixel starts a new file.
// ----------------------------------------------------------------------------
// png_stored_stream_encoder_top
// Byte sequencer that wraps RGBA pixels into a PNG file of stored blocks.
// ----------------------------------------------------------------------------
module png_stored_stream_encoder_top
    import pse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    pse_pix_if.sink           pix,
    pse_byte_if.source        bytes
);
    `include "png_stored_stream_encoder_top_assert.svh"

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_HEAD  = 7'b0000010,
        ST_BHDR  = 7'b0000100,
        ST_RAW   = 7'b0001000,
        ST_TAIL  = 7'b0010000,
        ST_WAIT  = 7'b0100000,
        ST_CALC  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] width_cfg_reg, height_cfg_reg;
    logic [SIDE_W-1:0] lat_w_reg, lat_h_reg;
    logic [13:0] col_reg, row_reg;
    logic [15:0] blk_left_reg;
    logic [31:0] raw_left_reg;
    logic [31:0] idat_len_reg;
    logic        in_file_reg;
    logic [5:0]  idx_reg;
    logic [2:0]  rawi_reg;   // 0 filter, 1..4 components
    logic [31:0] pix_reg;
    logic        o_valid_reg;
    pse_out_t    o_reg;
    // IDAT length computation: raw size plus rounding, then block count
    logic [31:0] rem_reg;
    logic [15:0] nblk_reg;
    logic [1:0]  calc_reg;
    logic [16:0] blk_fold;

    logic        crc_init, crc_en, adl_init, adl_en;
    logic [7:0]  unit_din;
    logic [31:0] crc;
    logic [15:0] adl_low, adl_high;

    pse_crc_unit u_crc (
        .clk(clk), .rst_n(rst_n), .crc_init(crc_init), .crc_en(crc_en),
        .adl_init(adl_init), .adl_en(adl_en), .din(unit_din), .crc(crc),
        .adl_low(adl_low), .adl_high(adl_high)
    );

    // a byte may be emitted when the output register is empty or drains
    logic emit_ok;
    assign emit_ok = !o_valid_reg || bytes.ready;
    assign pix.ready = (state_reg == ST_IDLE);
    assign bytes.valid = o_valid_reg;
    assign bytes.data  = o_reg;

    logic [31:0] raw_total;
    logic [15:0] blk_size;
    logic        last_pix;
    assign raw_total = 32'(lat_h_reg) * (32'd1 + {15'd0, lat_w_reg, 2'b00});
    assign blk_size  = (raw_left_reg > 32'(BLOCK_LIMIT)) ? 16'(BLOCK_LIMIT) : raw_left_reg[15:0];
    assign last_pix  = ({1'b0, col_reg} + 15'd1 >= lat_w_reg) &&
                       ({1'b0, row_reg} + 15'd1 >= lat_h_reg);
    // BLOCK_LIMIT is 2^16-1: fold the high half onto the low half
    assign blk_fold  = {1'b0, rem_reg[31:16]} + {1'b0, rem_reg[15:0]};

    // header byte by index (signature, IHDR, IDAT length/type, zlib)
    logic [7:0] head_byte;
    logic       head_crc;
    always_comb
    begin
        head_crc = 1'b0;
        unique case (idx_reg)
            6'd0:  head_byte = 8'd137;
            6'd1:  head_byte = 8'd80;
            6'd2:  head_byte = 8'd78;
            6'd3:  head_byte = 8'd71;
            6'd4:  head_byte = 8'd13;
            6'd5:  head_byte = 8'd10;
            6'd6:  head_byte = 8'd26;
            6'd7:  head_byte = 8'd10;
            6'd8, 6'd9, 6'd10: head_byte = 8'd0;
            6'd11: head_byte = 8'd13;
            6'd12: begin head_byte = 8'h49; head_crc = 1'b1; end
            6'd13: begin head_byte = 8'h48; head_crc = 1'b1; end
            6'd14: begin head_byte = 8'h44; head_crc = 1'b1; end
            6'd15: begin head_byte = 8'h52; head_crc = 1'b1; end
            6'd16, 6'd17: begin head_byte = 8'd0; head_crc = 1'b1; end
            6'd18: begin head_byte = {1'b0, lat_w_reg[14:8]}; head_crc = 1'b1; end
            6'd19: begin head_byte = lat_w_reg[7:0]; head_crc = 1'b1; end
            6'd20, 6'd21: begin head_byte = 8'd0; head_crc = 1'b1; end
            6'd22: begin head_byte = {1'b0, lat_h_reg[14:8]}; head_crc = 1'b1; end
            6'd23: begin head_byte = lat_h_reg[7:0]; head_crc = 1'b1; end
            6'd24: begin head_byte = 8'd8; head_crc = 1'b1; end
            6'd25: begin head_byte = 8'd6; head_crc = 1'b1; end
            6'd26, 6'd27, 6'd28: begin head_byte = 8'd0; head_crc = 1'b1; end
            6'd29: head_byte = ~crc[31:24];
            6'd30: head_byte = ~crc[23:16];
            6'd31: head_byte = ~crc[15:8];
            6'd32: head_byte = ~crc[7:0];
            6'd33: head_byte = idat_len_reg[31:24];
            6'd34: head_byte = idat_len_reg[23:16];
            6'd35: head_byte = idat_len_reg[15:8];
            6'd36: head_byte = idat_len_reg[7:0];
            6'd37: begin head_byte = 8'h49; head_crc = 1'b1; end
            6'd38: begin head_byte = 8'h44; head_crc = 1'b1; end
            6'd39: begin head_byte = 8'h41; head_crc = 1'b1; end
            6'd40: begin head_byte = 8'h54; head_crc = 1'b1; end
            6'd41: begin head_byte = 8'h78; head_crc = 1'b1; end
            6'd42: begin head_byte = 8'h01; head_crc = 1'b1; end
            default: head_byte = 8'd0;
        endcase
    end

    // block header byte by index
    logic [7:0] bhdr_byte;
    always_comb
    begin
        unique case (idx_reg[2:0])
            3'd0:    bhdr_byte = {7'd0, raw_left_reg <= 32'(BLOCK_LIMIT)};
            3'd1:    bhdr_byte = blk_size[7:0];
            3'd2:    bhdr_byte = blk_size[15:8];
            3'd3:    bhdr_byte = ~blk_size[7:0];
            default: bhdr_byte = ~blk_size[15:8];
        endcase
    end

    // raw byte: filter byte or a component
    logic [7:0] raw_byte;
    always_comb
    begin
        unique case (rawi_reg)
            3'd1:    raw_byte = pix_reg[31:24];
            3'd2:    raw_byte = pix_reg[23:16];
            3'd3:    raw_byte = pix_reg[15:8];
            3'd4:    raw_byte = pix_reg[7:0];
            default: raw_byte = 8'd0;
        endcase
    end

    // trailer: Adler (with CRC), IDAT CRC, IEND
    logic [7:0] tail_byte;
    always_comb
    begin
        if (idx_reg < 6'd4)
        begin
            unique case (idx_reg[1:0])
                2'd0: tail_byte = adl_high[15:8];
                2'd1: tail_byte = adl_high[7:0];
                2'd2: tail_byte = adl_low[15:8];
                default: tail_byte = adl_low[7:0];
            endcase
        end
        else if (idx_reg < 6'd8)
        begin
            // CRC holds still once the Adler bytes are in
            unique case (idx_reg[1:0])
                2'd0: tail_byte = ~crc[31:24];
                2'd1: tail_byte = ~crc[23:16];
                2'd2: tail_byte = ~crc[15:8];
                default: tail_byte = ~crc[7:0];
            endcase
        end
        else
            tail_byte = iend_byte(4'(idx_reg - 6'd8));
    end

    // sequencer
    logic [7:0] emit_byte;
    logic       emit, emit_last, emit_end;
    always_comb
    begin
        state_next = state_reg;
        emit = 1'b0; emit_byte = 8'd0; emit_last = 1'b0; emit_end = 1'b0;
        crc_init = 1'b0; crc_en = 1'b0; adl_init = 1'b0; adl_en = 1'b0;
        unit_din = 8'd0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pix.valid)
                    state_next = in_file_reg ? ST_RAW : ST_CALC;
            end
            ST_CALC: if (calc_reg == 2'd2) state_next = ST_HEAD;
            ST_HEAD:
            begin
                emit_byte = head_byte;
                unit_din  = head_byte;
                if (emit_ok)
                begin
                    emit = 1'b1;
                    crc_en = head_crc;
                    crc_init = (idx_reg == 6'd11) || (idx_reg == 6'd36);
                    if (idx_reg == 6'd42)
                    begin
                        adl_init = 1'b1;
                        state_next = ST_RAW;
                    end
                end
            end
            ST_BHDR:
            begin
                emit_byte = bhdr_byte;
                unit_din  = bhdr_byte;
                if (emit_ok)
                begin
                    emit = 1'b1; crc_en = 1'b1;
                    if (idx_reg[2:0] == 3'd4) state_next = ST_RAW;
                end
            end
            ST_RAW:
            begin
                if (blk_left_reg == 16'd0)
                    state_next = ST_BHDR;
                else
                begin
                    emit_byte = raw_byte;
                    unit_din  = raw_byte;
                    emit_last = (rawi_reg == 3'd4) && !last_pix;
                    if (emit_ok)
                    begin
                        emit = 1'b1; crc_en = 1'b1; adl_en = 1'b1;
                        if (rawi_reg == 3'd4)
                            state_next = last_pix ? ST_WAIT : ST_IDLE;
                    end
                end
            end
            ST_WAIT: state_next = ST_TAIL;
            ST_TAIL:
            begin
                emit_byte = tail_byte;
                unit_din  = tail_byte;
                emit_last = (idx_reg == 6'd19);
                emit_end  = emit_last;
                if (emit_ok)
                begin
                    emit = 1'b1;
                    crc_en = (idx_reg < 6'd4);
                    if (idx_reg == 6'd19) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= CFG_W'(2);
            height_cfg_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_cfg_reg  <= cfg_data;
                CFG_HEIGHT: height_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic pix_acc;
    assign pix_acc = pix.valid && pix.ready;

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_file_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            blk_left_reg <= '0;
            raw_left_reg <= '0;
            idx_reg      <= '0;
            rawi_reg     <= '0;
            pix_reg      <= '0;
            lat_w_reg    <= '0;
            lat_h_reg    <= '0;
            rem_reg      <= '0;
            nblk_reg     <= '0;
            calc_reg     <= '0;
            idat_len_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                o_valid_reg <= 1'b1;
            else if (bytes.ready)
                o_valid_reg <= 1'b0;

            if (pix_acc)
            begin
                rawi_reg <= (col_reg == 14'd0 || !in_file_reg) ? 3'd0 : 3'd1;
                idx_reg  <= '0;
                pix_reg  <= pix.data;
                if (!in_file_reg)
                begin
                    lat_w_reg <= (width_cfg_reg < 15'd2) ? 15'd2 :
                        (width_cfg_reg > 15'(MAX_SIDE)) ? 15'(MAX_SIDE) : width_cfg_reg;
                    lat_h_reg <= (height_cfg_reg < 15'd1) ? 15'd1 :
                        (height_cfg_reg > 15'(MAX_SIDE)) ? 15'(MAX_SIDE) : height_cfg_reg;
                    col_reg  <= '0;
                    row_reg  <= '0;
                    calc_reg <= '0;
                end
            end

            // raw size, block count rounded up, then IDAT length
            if (state_reg == ST_CALC)
            begin
                calc_reg <= calc_reg + 2'd1;
                unique case (calc_reg)
                    2'd0:
                    begin
                        rem_reg      <= raw_total + 32'(BLOCK_LIMIT - 1);
                        raw_left_reg <= raw_total;
                        blk_left_reg <= '0;
                    end
                    2'd1:
                    begin
                        nblk_reg <= rem_reg[31:16] +
                                    ((blk_fold >= 17'd131070) ? 16'd2 :
                                     (blk_fold >= 17'd65535)  ? 16'd1 : 16'd0);
                    end
                    default:
                    begin
                        idat_len_reg <= raw_left_reg + 32'd6 + 32'(nblk_reg) * 32'd5;
                        in_file_reg  <= 1'b1;
                    end
                endcase
            end

            if (emit)
            begin
                if (state_reg == ST_RAW)
                begin
                    rawi_reg <= rawi_reg + 3'd1;
                    blk_left_reg <= blk_left_reg - 16'd1;
                    raw_left_reg <= raw_left_reg - 32'd1;
                    if (rawi_reg == 3'd4)
                    begin
                        if ({1'b0, col_reg} + 15'd1 >= lat_w_reg)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + 14'd1;
                        end
                        else
                            col_reg <= col_reg + 14'd1;
                    end
                end
                else if (state_reg == ST_BHDR && idx_reg[2:0] == 3'd4)
                begin
                    blk_left_reg <= blk_size;
                    idx_reg <= '0;
                end
                else if (state_reg == ST_HEAD && idx_reg == 6'd42)
                    idx_reg <= '0;
                else if (state_reg == ST_TAIL && idx_reg == 6'd19)
                begin
                    idx_reg <= '0;
                    in_file_reg <= 1'b0;
                end
                else
                    idx_reg <= idx_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            o_reg.out_byte <= emit_byte;
            o_reg.run_last <= emit_last;
            o_reg.file_end <= emit_end;
        end
    end

    `PSE_ASSERT_IMP(a_no_overwrite, o_valid_reg && !bytes.ready, !emit)
    `PSE_ASSERT_IMP(a_ready_idle, pix.ready, !emit)
    `PSE_ASSERT_NEXT(a_end_last, emit && emit_end, o_reg.run_last)
endmodule
